@@ design/event_message_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// Event message parser - assertion macros
// Immediate-style wrappers for clocked concurrent checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef EVENT_MESSAGE_PARSER_CORE_ASSERT_SVH
`define EVENT_MESSAGE_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define EMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EMP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/emp_pkg.sv @@
// ----------------------------------------------------------------------------
// Event message parser - package
// Keyword table, result kinds, event codes and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package emp_pkg;

    localparam int KW_NUM          = 8;
    localparam int KW_CHARS        = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] CODE_RECEIVED = 3'd4;
    localparam logic [2:0] CODE_SEND     = 3'd6;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [30:0] HANDLE_MAX = 31'h7FFF_FFFF;

    // left aligned, padded past each keyword's length
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
        "ACCEPTED", "CLOSED..", "CLOSING.", "ERROR...",
        "RECEIVED", "CLOSE...", "SEND....", "SHUTDOWN"
    };

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd8, 4'd6, 4'd7, 4'd5, 4'd8, 4'd5, 4'd4, 4'd8
    };

    typedef struct packed {
        logic [7:0]                             char_val;
        logic                                   last;
        logic                                   is_space;
        logic                                   is_digit;
        logic [KW_NUM-1:0][KW_CHARS-1:0]        hits;
    } emp_item_t;

    function automatic logic [7:0] kw_char(input int k, input int i);
        return KW_TEXT[k][8*(KW_CHARS-1-i) +: 8];
    endfunction

endpackage

`default_nettype wire

@@ design/event_message_parser_core.sv @@
// Throughput: one byte per cycle, sustained, while the result side keeps up.
// A taken byte passes through the item queue and then the result register; a result is held while stalled.
// The result register frees as it is taken; a two-entry queue absorbs result stalls.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result
// and returns the parser to the keyword field with all counts cleared.
// ----------------------------------------------------------------------------
// Event message parser - top level
// Byte-stream parser for event keyword, handle and payload messages.
// ----------------------------------------------------------------------------
`default_nettype none

module event_message_parser_core
#(
    parameter int QUEUE_DEPTH = emp_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          msg_valid,
    output logic               msg_stall,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               res_valid,
    input  wire logic          res_stall,
    output logic [1:0]         kind,
    output logic [2:0]         event_code,
    output logic [30:0]        handle_value,
    output logic [7:0]         data_byte,
    output logic               end_of_message
);
    import emp_pkg::*;

    emp_item_t front_item;
    emp_item_t head_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_not_empty;

    emp_front u_front
    (
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .full      (q_full),
        .push      (push),
        .item      (front_item)
    );

    emp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (front_item),
        .pop       (pop),
        .item_out  (head_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    emp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (head_item),
        .item_valid     (q_not_empty),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .kind           (kind),
        .event_code     (event_code),
        .handle_value   (handle_value),
        .data_byte      (data_byte),
        .end_of_message (end_of_message)
    );

endmodule

`default_nettype wire

@@ design/emp_front.sv @@
// ----------------------------------------------------------------------------
// Event message parser - front end
// Takes bytes in and classifies them: space, digit, and a per-keyword,
// per-position character compare for the back end to pick from.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_front
(
    input  wire logic              msg_valid,
    output logic                   msg_stall,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic              full,
    output logic                   push,
    output emp_pkg::emp_item_t     item
);
    import emp_pkg::*;

    assign msg_stall = full;
    assign push      = msg_valid && !full;

    always_comb
    begin
        item.char_val = in_byte;
        item.last     = in_last;
        item.is_space = (in_byte == CHAR_SPACE);
        item.is_digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
        for (int k = 0; k < KW_NUM; k++)
        begin
            for (int i = 0; i < KW_CHARS; i++)
            begin
                item.hits[k][i] = (in_byte == kw_char(k, i));
            end
        end
    end

endmodule

`default_nettype wire

@@ design/emp_queue.sv @@
// ----------------------------------------------------------------------------
// Event message parser - item queue
// Short register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_queue
#(
    parameter int DEPTH = emp_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire emp_pkg::emp_item_t  item_in,
    input  wire logic                pop,
    output emp_pkg::emp_item_t       item_out,
    output logic                     not_empty,
    output logic                     full
);
    import emp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    emp_item_t        mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign item_out  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

@@ design/emp_back.sv @@
// ----------------------------------------------------------------------------
// Event message parser - back end
// Field state machine: keyword match, handle accumulate, data pass-through,
// end-of-message verdict, and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire emp_pkg::emp_item_t  item,
    input  wire logic                item_valid,
    output logic                     pop,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [1:0]               kind,
    output logic [2:0]               event_code,
    output logic [30:0]              handle_value,
    output logic [7:0]               data_byte,
    output logic                     end_of_message
);
    import emp_pkg::*;

    localparam logic [1:0] PH_KEYWORD = 2'd0;
    localparam logic [1:0] PH_HANDLE  = 2'd1;
    localparam logic [1:0] PH_DATA    = 2'd2;
    localparam logic [1:0] PH_SKIP    = 2'd3;

    function automatic logic is_data_event(input logic [2:0] code);
        return (code == CODE_RECEIVED) || (code == CODE_SEND);
    endfunction

    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [KW_NUM-1:0] match_reg, match_next;
    logic [30:0]       accum_reg, accum_next;
    logic [2:0]        code_reg, code_next;
    logic              fault_reg, fault_next;

    logic              res_valid_reg;
    logic [1:0]        kind_reg;
    logic [2:0]        code_out_reg;
    logic [30:0]       handle_reg;
    logic [7:0]        data_reg;
    logic              eom_reg;

    logic              emit;
    logic [1:0]        r_kind;
    logic [2:0]        r_code;
    logic [30:0]       r_handle;
    logic [7:0]        r_data;
    logic              ok;
    logic              adv;
    logic              kw_found;
    logic [2:0]        kw_code;
    logic [34:0]       acc_sum;

    assign adv = !res_valid_reg || !res_stall;
    assign pop = item_valid && adv;

    always_comb
    begin
        kw_found = 1'b0;
        kw_code  = '0;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            if (match_reg[k] && (cnt_reg == KW_LEN[k]))
            begin
                kw_found = 1'b1;
                kw_code  = 3'(k);
            end
        end
    end

    // x10 as shift-add, plus digit
    assign acc_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + {31'd0, item.char_val[3:0]};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        match_next = match_reg;
        accum_next = accum_reg;
        code_next  = code_reg;
        fault_next = fault_reg;
        emit       = 1'b0;
        r_kind     = KIND_HEADER;
        r_code     = code_reg;
        r_handle   = accum_reg;
        r_data     = '0;
        ok         = 1'b0;

        unique case (phase_reg)
            PH_KEYWORD:
            begin
                if (item.is_space)
                begin
                    accum_next = '0;
                    if (kw_found)
                    begin
                        code_next  = kw_code;
                        phase_next = PH_HANDLE;
                    end
                    else
                    begin
                        fault_next = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    for (int k = 0; k < KW_NUM; k++)
                    begin
                        match_next[k] = match_reg[k] && !cnt_reg[3]
                                        && item.hits[k][cnt_reg[2:0]];
                    end
                    if (cnt_reg != 4'hF)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            PH_HANDLE:
            begin
                if (item.is_space)
                begin
                    if (!fault_reg && is_data_event(code_reg))
                    begin
                        emit       = 1'b1;
                        r_kind     = KIND_HEADER;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                else if (item.is_digit)
                begin
                    if (acc_sum > {4'd0, HANDLE_MAX})
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        accum_next = acc_sum[30:0];
                    end
                end
                else
                begin
                    fault_next = 1'b1;
                end
            end
            PH_DATA:
            begin
                emit   = 1'b1;
                r_kind = KIND_DATA;
                r_data = item.char_val;
            end
            PH_SKIP:
            begin
            end
        endcase

        if (item.last)
        begin
            if (!emit)
            begin
                priority if (phase_next == PH_KEYWORD)
                begin
                    ok = 1'b0;
                end
                else if (phase_next == PH_HANDLE)
                begin
                    ok = !fault_next && !is_data_event(code_next);
                end
                else
                begin
                    ok = !fault_next;
                end
                emit = 1'b1;
                if (ok)
                begin
                    r_kind   = KIND_HEADER;
                    r_code   = code_next;
                    r_handle = accum_next;
                end
                else
                begin
                    r_kind   = KIND_ERROR;
                    r_code   = '0;
                    r_handle = '0;
                end
                r_data = '0;
            end
            phase_next = PH_KEYWORD;
            cnt_next   = '0;
            match_next = '1;
            accum_next = '0;
            code_next  = '0;
            fault_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_KEYWORD;
            cnt_reg       <= '0;
            match_reg     <= '1;
            accum_reg     <= '0;
            code_reg      <= '0;
            fault_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                match_reg <= match_next;
                accum_reg <= accum_next;
                code_reg  <= code_next;
                fault_reg <= fault_next;
            end
            if (adv)
            begin
                res_valid_reg <= pop && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg     <= r_kind;
            code_out_reg <= r_code;
            handle_reg   <= r_handle;
            data_reg     <= r_data;
            eom_reg      <= item.last;
        end
    end

    assign res_valid      = res_valid_reg;
    assign kind           = kind_reg;
    assign event_code     = code_out_reg;
    assign handle_value   = handle_reg;
    assign data_byte      = data_reg;
    assign end_of_message = eom_reg;

endmodule

`default_nettype wire

@@ design/emp_checker.sv @@
// ----------------------------------------------------------------------------
// Event message parser - port checker
// Result-side checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "event_message_parser_core_assert.svh"

module emp_checker
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          res_valid,
    input  wire logic          res_stall,
    input  wire logic [1:0]    kind,
    input  wire logic [2:0]    event_code,
    input  wire logic [30:0]   handle_value,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_message
);
    import emp_pkg::*;

    `EMP_ASSERT_NOW(a_error_fields, res_valid && (kind == KIND_ERROR), (event_code == '0) && (handle_value == '0) && (data_byte == '0) && end_of_message, "error result with non-zero fields")

    `EMP_ASSERT_NOW(a_header_no_data, res_valid && (kind == KIND_HEADER), data_byte == '0, "header result carries a data byte")

    `EMP_ASSERT_NOW(a_data_event, res_valid && (kind == KIND_DATA), (event_code == CODE_RECEIVED) || (event_code == CODE_SEND), "data result for an event without payload")

    `EMP_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable({kind, event_code, handle_value, data_byte, end_of_message}), "stalled result changed")

endmodule

bind event_message_parser_core emp_checker u_emp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .event_code     (event_code),
    .handle_value   (handle_value),
    .data_byte      (data_byte),
    .end_of_message (end_of_message)
);

`default_nettype wire
